### design/mck_pkg.sv
// shared types, constants and the character table of the morse keyer
// no dependencies; used by every other file of the keyer
package mck_pkg;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned ROM_DEPTH = 28;
  localparam int unsigned ROM_IDX_W = $clog2(ROM_DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_CHAR  = 2'd1,
    REQ_PAUSE = 2'd2
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 8'd3;

  localparam logic [TICK_W-1:0] DOT_RST   = 8'd3;
  localparam logic [TICK_W-1:0] DASH_RST  = 8'd9;
  localparam logic [TICK_W-1:0] GAP_RST   = 8'd3;
  localparam logic [TICK_W-1:0] PAUSE_RST = 8'd12;

  localparam logic [CODE_W-1:0] PAUSE_MARK = 16'hC000;
  localparam logic [CODE_W-1:0] PAUSE_HOLD = 16'h8000;
  localparam logic [CODE_W-1:0] PAUSE_CLR  = 16'h3FFF;

  localparam logic [1:0] EL_DOT     = 2'b01;
  localparam logic [1:0] EL_SILENCE = 2'b11;

  localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SPC  = 8'h20;

  localparam logic [ROM_IDX_W-1:0] IDX_DOT = 5'd26;
  localparam logic [ROM_IDX_W-1:0] IDX_SPC = 5'd27;

  // letters a to z, then '.', then space
  localparam logic [CODE_W-1:0] MORSE_ROM [ROM_DEPTH] = '{
    16'h0009, 16'h0056, 16'h0066, 16'h0016, 16'h0001, 16'h0065, 16'h001A, 16'h0055,
    16'h0005, 16'h00A9, 16'h0026, 16'h0059, 16'h000A, 16'h0006, 16'h002A, 16'h0069,
    16'h009A, 16'h0019, 16'h0015, 16'h0002, 16'h0025, 16'h0095, 16'h0029, 16'h0096,
    16'h00A6, 16'h005A, 16'h0155, 16'h0003
  };

  typedef struct packed {
    logic [TICK_W-1:0] dot_ticks;
    logic [TICK_W-1:0] dash_ticks;
    logic [TICK_W-1:0] element_gap_ticks;
    logic [TICK_W-1:0] letter_pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic bad_char;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              bad;
  } lookup_t;

endpackage

### design/mck_if.sv
// valid/ready channel interfaces of the morse keyer: request, result, config
// depends on mck_pkg for widths
interface mck_in_if;
  logic                        valid;
  logic                        ready;
  logic [mck_pkg::REQ_W-1:0]   req_type;
  logic [mck_pkg::CHAR_W-1:0]  char_code;
  modport source (output valid, req_type, char_code, input ready);
  modport sink (input valid, req_type, char_code, output ready);
endinterface

interface mck_out_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic bad_char;
  modport source (output valid, led_on, busy_res, bad_char, input ready);
  modport sink (input valid, led_on, busy_res, bad_char, output ready);
endinterface

interface mck_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mck_pkg::CFG_IDX_W-1:0] index;
  logic [mck_pkg::TICK_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/mck_lookup.sv
// character to morse code lookup through the constant table
// depends on mck_pkg
module mck_lookup (
  input  logic [mck_pkg::CHAR_W-1:0] char_code,
  output mck_pkg::lookup_t           lookup
);

  logic [mck_pkg::ROM_IDX_W-1:0] idx;
  logic                          hit;
  logic [mck_pkg::CHAR_W-1:0]    up_off;
  logic [mck_pkg::CHAR_W-1:0]    lo_off;

  assign up_off = char_code - mck_pkg::CH_UP_A;
  assign lo_off = char_code - mck_pkg::CH_LO_A;

  always_comb begin
    idx = '0;
    hit = 1'b1;
    priority if (char_code >= mck_pkg::CH_UP_A && char_code <= mck_pkg::CH_UP_Z) begin
      idx = up_off[mck_pkg::ROM_IDX_W-1:0];
    end else if (char_code >= mck_pkg::CH_LO_A && char_code <= mck_pkg::CH_LO_Z) begin
      idx = lo_off[mck_pkg::ROM_IDX_W-1:0];
    end else if (char_code == mck_pkg::CH_DOT) begin
      idx = mck_pkg::IDX_DOT;
    end else if (char_code == mck_pkg::CH_SPC) begin
      idx = mck_pkg::IDX_SPC;
    end else begin
      hit = 1'b0;
    end
  end

  assign lookup.code = mck_pkg::MORSE_ROM[idx];
  assign lookup.bad  = ~hit;

endmodule

### design/mck_keyer.sv
// keying state machine: code shift register, tick counter, state and led level
// depends on mck_pkg and mck_lookup
module mck_keyer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [mck_pkg::REQ_W-1:0]   req_type,
  input  logic [mck_pkg::CHAR_W-1:0]  char_code,
  input  mck_pkg::cfg_t               cfg,
  output mck_pkg::result_t            result
);

  typedef enum logic [1:0] {
    ST_START = 2'd0,
    ST_ON    = 2'd1,
    ST_PAUSE = 2'd2
  } key_state_t;

  key_state_t                   state_r, state_nxt;
  logic [mck_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic [mck_pkg::TICK_W-1:0]   cnt_r, cnt_nxt;
  logic                         led_r, led_nxt;
  logic                         bad;
  mck_pkg::lookup_t             lookup;

  mck_lookup u_lookup (
    .char_code (char_code),
    .lookup    (lookup)
  );

  always_comb begin
    code_nxt  = code_r;
    cnt_nxt   = cnt_r;
    state_nxt = state_r;
    led_nxt   = led_r;
    bad       = 1'b0;
    unique case (req_type)
      mck_pkg::REQ_TICK: begin
        if (code_nxt == mck_pkg::PAUSE_MARK) begin
          code_nxt  = mck_pkg::PAUSE_HOLD;
          cnt_nxt   = cfg.letter_pause_ticks;
          led_nxt   = 1'b0;
          state_nxt = ST_PAUSE;
        end
        unique case (state_nxt)
          ST_ON: begin
            if (cnt_nxt == '0) begin
              code_nxt = code_nxt >> 2;
              if (code_nxt != '0) begin
                cnt_nxt   = cfg.element_gap_ticks;
                state_nxt = ST_PAUSE;
              end else begin
                state_nxt = ST_START;
              end
              led_nxt = 1'b0;
            end
          end
          ST_PAUSE: begin
            if (cnt_nxt == '0) begin
              if ((code_nxt & mck_pkg::PAUSE_MARK) != '0) begin
                code_nxt  = code_nxt & mck_pkg::PAUSE_CLR;
                state_nxt = ST_START;
              end else if (code_nxt != '0) begin
                cnt_nxt   = (code_nxt[1:0] == mck_pkg::EL_DOT) ?
                            cfg.dot_ticks : cfg.dash_ticks;
                state_nxt = ST_ON;
                led_nxt   = (code_nxt[1:0] != mck_pkg::EL_SILENCE);
              end
            end
          end
          default: begin
            // start state, and the unused code acts like it
            if (code_nxt != '0) begin
              cnt_nxt   = (code_nxt[1:0] == mck_pkg::EL_DOT) ?
                          cfg.dot_ticks : cfg.dash_ticks;
              state_nxt = ST_ON;
              led_nxt   = (code_nxt[1:0] != mck_pkg::EL_SILENCE);
            end
          end
        endcase
        if (cnt_nxt != '0) begin
          cnt_nxt = cnt_nxt - 1'b1;
        end
      end
      mck_pkg::REQ_CHAR: begin
        if (lookup.bad) begin
          bad = 1'b1;
        end else begin
          code_nxt = lookup.code;
        end
      end
      mck_pkg::REQ_PAUSE: begin
        code_nxt = mck_pkg::PAUSE_MARK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      code_r  <= '0;
      cnt_r   <= '0;
      led_r   <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      cnt_r   <= cnt_nxt;
      led_r   <= led_nxt;
    end
  end

  assign result.led_on   = led_nxt;
  assign result.busy_res = (code_nxt != '0);
  assign result.bad_char = bad;

endmodule

### design/morse_code_keyer.sv
// morse keyer top: request register, keying state machine, result register
// result is registered after the request; one request per cycle if not stalled
// a stalled result keeps one more request in the input register
// config writes are taken every cycle and apply to the next processed request
// synchronous active-low reset clears the keyer state and loads default timings
// depends on mck_pkg, mck_if, mck_keyer
module morse_code_keyer (
  input  logic           clk,
  input  logic           rst_n,
  mck_in_if.sink         in_ch,
  mck_out_if.source      out_ch,
  mck_cfg_if.sink        cfg_ch
);

  logic                        in_valid_r;
  logic [mck_pkg::REQ_W-1:0]   in_req_r;
  logic [mck_pkg::CHAR_W-1:0]  in_char_r;
  logic                        out_valid_r;
  mck_pkg::result_t            out_res_r;
  mck_pkg::result_t            result;
  mck_pkg::cfg_t               cfg_r;
  logic                        advance;
  logic                        step;

  assign advance      = !out_valid_r || out_ch.ready;
  assign step         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_ticks          <= mck_pkg::DOT_RST;
      cfg_r.dash_ticks         <= mck_pkg::DASH_RST;
      cfg_r.element_gap_ticks  <= mck_pkg::GAP_RST;
      cfg_r.letter_pause_ticks <= mck_pkg::PAUSE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mck_pkg::CFG_DOT:   cfg_r.dot_ticks          <= cfg_ch.data;
        mck_pkg::CFG_DASH:  cfg_r.dash_ticks         <= cfg_ch.data;
        mck_pkg::CFG_GAP:   cfg_r.element_gap_ticks  <= cfg_ch.data;
        mck_pkg::CFG_PAUSE: cfg_r.letter_pause_ticks <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_req_r  <= in_ch.req_type;
      in_char_r <= in_ch.char_code;
    end
  end

  mck_keyer u_keyer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req_type  (in_req_r),
    .char_code (in_char_r),
    .cfg       (cfg_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.led_on   = out_res_r.led_on;
  assign out_ch.busy_res = out_res_r.busy_res;
  assign out_ch.bad_char = out_res_r.bad_char;

  // a pause request always leaves the code register busy
  a_pause_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_req_r == mck_pkg::REQ_PAUSE |=> out_valid_r && out_res_r.busy_res)
    else $error("pause request gave an idle result");

  // only a character request can flag a bad character
  a_bad_only_char: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_req_r != mck_pkg::REQ_CHAR |=> !out_res_r.bad_char)
    else $error("bad character flagged on a non-character request");

  // a held request is not dropped while the result side stalls
  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_req_r) && $stable(in_char_r))
    else $error("pending request lost under stall");

  // a processed request always produces a result
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("request processed without a result");

endmodule

### tb/mck_keyer_checker.sv
// checker for the morse keyer: watches request, result and config channels,
// predicts every result and compares it field by field
// depends on mck_pkg and the channel interfaces in mck_if
module mck_keyer_checker
  import mck_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mck_in_if    in_ch,
  mck_out_if   out_ch,
  mck_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [1:0] {
    KEY_START = 2'd0,
    KEY_ON    = 2'd1,
    KEY_GAP   = 2'd2
  } key_phase_t;

  localparam logic [CODE_W-1:0] LETTER_MARK = 16'hC000;
  localparam logic [CODE_W-1:0] HOLD_MARK   = 16'h8000;
  localparam logic [CODE_W-1:0] MARK_MASK   = 16'h3FFF;
  localparam logic [1:0]        ELEM_DOT    = 2'b01;
  localparam logic [1:0]        ELEM_SILENT = 2'b11;

  // a to z, then '.', then space
  localparam logic [CODE_W-1:0] CHAR_CODES [ROM_DEPTH] = '{
    16'h0009, 16'h0056, 16'h0066, 16'h0016, 16'h0001, 16'h0065, 16'h001A,
    16'h0055, 16'h0005, 16'h00A9, 16'h0026, 16'h0059, 16'h000A, 16'h0006,
    16'h002A, 16'h0069, 16'h009A, 16'h0019, 16'h0015, 16'h0002, 16'h0025,
    16'h0095, 16'h0029, 16'h0096, 16'h00A6, 16'h005A, 16'h0155, 16'h0003
  };

  cfg_t              timing;
  logic [CODE_W-1:0] code_reg;
  logic [TICK_W-1:0] tick_cnt;
  key_phase_t        phase;
  logic              led_lvl;
  result_t           keying_q [$];
  int                fails;

  function automatic void begin_element();
    tick_cnt = (code_reg[1:0] == ELEM_DOT) ? timing.dot_ticks : timing.dash_ticks;
    phase    = KEY_ON;
    led_lvl  = (code_reg[1:0] != ELEM_SILENT);
  endfunction

  function automatic result_t predict_keying(input logic [REQ_W-1:0] req,
                                             input logic [CHAR_W-1:0] ch);
    result_t r;
    r.bad_char = 1'b0;
    case (req)
      REQ_TICK: begin
        // a fresh letter pause marker turns into the held pause first
        if (code_reg == LETTER_MARK) begin
          code_reg = HOLD_MARK;
          tick_cnt = timing.letter_pause_ticks;
          led_lvl  = 1'b0;
          phase    = KEY_GAP;
        end
        case (phase)
          KEY_ON: if (tick_cnt == '0) begin
            code_reg = code_reg >> 2;
            if (code_reg != '0) begin
              tick_cnt = timing.element_gap_ticks;
              phase    = KEY_GAP;
            end else begin
              phase = KEY_START;
            end
            led_lvl = 1'b0;
          end
          KEY_GAP: if (tick_cnt == '0) begin
            if ((code_reg & LETTER_MARK) != '0) begin
              code_reg = code_reg & MARK_MASK;
              phase    = KEY_START;
            end else if (code_reg != '0) begin
              begin_element();
            end
          end
          default: if (code_reg != '0) begin
            begin_element();
          end
        endcase
        if (tick_cnt != '0) tick_cnt = tick_cnt - 1'b1;
      end
      REQ_CHAR: begin
        if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
          code_reg = CHAR_CODES[ch - CH_UP_A];
        end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
          code_reg = CHAR_CODES[ch - CH_LO_A];
        end else if (ch == CH_DOT) begin
          code_reg = CHAR_CODES[IDX_DOT];
        end else if (ch == CH_SPC) begin
          code_reg = CHAR_CODES[IDX_SPC];
        end else begin
          r.bad_char = 1'b1;
        end
      end
      REQ_PAUSE: code_reg = LETTER_MARK;
      default: ;
    endcase
    r.led_on   = led_lvl;
    r.busy_res = (code_reg != '0);
    return r;
  endfunction

  function automatic void compare_bit(input string what, input logic want, input logic got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %b actual %b", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      timing.dot_ticks          = DOT_RST;
      timing.dash_ticks         = DASH_RST;
      timing.element_gap_ticks  = GAP_RST;
      timing.letter_pause_ticks = PAUSE_RST;
      code_reg = '0;
      tick_cnt = '0;
      phase    = KEY_START;
      led_lvl  = 1'b0;
      keying_q.delete();
      fails    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_DOT:   timing.dot_ticks          = cfg_ch.data;
          CFG_DASH:  timing.dash_ticks         = cfg_ch.data;
          CFG_GAP:   timing.element_gap_ticks  = cfg_ch.data;
          CFG_PAUSE: timing.letter_pause_ticks = cfg_ch.data;
          default: ;
        endcase
      end
      // pop before push: a result never leaves in the cycle its request enters
      if (out_ch.valid && out_ch.ready) begin
        if (keying_q.size() == 0) begin
          fails++;
          $display("%0t: result with no request, expected none actual led %b busy %b bad %b",
                   $time, out_ch.led_on, out_ch.busy_res, out_ch.bad_char);
        end else begin
          want = keying_q.pop_front();
          compare_bit("led_on", want.led_on, out_ch.led_on);
          compare_bit("busy_res", want.busy_res, out_ch.busy_res);
          compare_bit("bad_char", want.bad_char, out_ch.bad_char);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        keying_q.push_back(predict_keying(in_ch.req_type, in_ch.char_code));
      end
    end
    pending    <= keying_q.size();
    fail_count <= fails;
  end

endmodule

### tb/tb_morse_code_keyer.sv
// testbench top of the morse keyer: clock, reset, request and config stimulus,
// result-side stalls and the verdict; depends on mck_pkg, mck_if and the checker
module tb_morse_code_keyer;
  import mck_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE       = 2'd3;
  localparam int unsigned      CYCLE_LIMIT     = 400000;
  localparam int unsigned      HOLD_OFF_CYCLES = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   gaps_on     = 1'b1;
  bit   hold_off_go = 1'b0;
  int   fail_count;
  int   pending;

  mck_in_if  in_bus ();
  mck_out_if out_bus ();
  mck_cfg_if cfg_bus ();

  morse_code_keyer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  mck_keyer_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_ch     (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // result side: random ready bursts, one long hold-off on request
  initial begin : result_sink
    logic lvl;
    int   n;
    out_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        lvl = 1'b0;
        n   = HOLD_OFF_CYCLES;
      end else if (!gaps_on) begin
        lvl = 1'b1;
        n   = 1;
      end else begin
        lvl = ($urandom_range(0, 2) != 0);
        n   = $urandom_range(1, 18);
      end
      out_bus.ready <= lvl;
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.req_type  <= req;
    in_bus.char_code <= ch;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) send_req(REQ_TICK, 8'($urandom));
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // drain the keyer, then rewrite all timings plus one write to an unused index
  task automatic set_timing(input logic [TICK_W-1:0] dot, dash, gap, lp);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_put(CFG_DOT, dot);
    cfg_put(CFG_DASH, dash);
    cfg_put(CFG_GAP, gap);
    cfg_put(CFG_PAUSE, lp);
    cfg_put(8'($urandom_range(4, 255)), 8'($urandom));
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int               sent;
    int               pick;
    int               k;
    logic [CHAR_W-1:0] ch;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // a valid character, keyed for a while, often followed by a letter pause
        case ($urandom_range(0, 3))
          0: ch = CH_UP_A + 8'($urandom_range(0, 25));
          1: ch = CH_LO_A + 8'($urandom_range(0, 25));
          2: ch = CH_DOT;
          default: ch = CH_SPC;
        endcase
        send_req(REQ_CHAR, ch);
        k = $urandom_range(1, 40);
        run_ticks(k);
        sent += k + 1;
        if ($urandom_range(0, 2) == 0) begin
          send_req(REQ_PAUSE, 8'($urandom));
          k = $urandom_range(1, 20);
          run_ticks(k);
          sent += k + 1;
        end
      end else if (pick < 80) begin
        k = $urandom_range(1, 20);
        run_ticks(k);
        sent += k;
      end else if (pick < 88) begin
        send_req(REQ_PAUSE, 8'($urandom));
        sent++;
      end else if (pick < 96) begin
        send_req(REQ_CHAR, 8'($urandom));
        sent++;
      end else begin
        send_req(REQ_SPARE, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    in_bus.valid     = 1'b0;
    in_bus.req_type  = REQ_TICK;
    in_bus.char_code = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_DOT;
    cfg_bus.data     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset timings
    send_req(REQ_CHAR, CH_UP_A);
    run_ticks(30);
    send_req(REQ_PAUSE, 8'h00);
    run_ticks(20);
    send_req(REQ_CHAR, CH_LO_Z);
    run_ticks(8);
    // load while busy
    send_req(REQ_CHAR, CH_DOT);
    run_ticks(50);
    // space keys a silence element
    send_req(REQ_CHAR, CH_SPC);
    run_ticks(16);
    send_req(REQ_CHAR, CH_UP_Z);
    run_ticks(4);
    send_req(REQ_CHAR, CH_LO_A);
    run_ticks(4);
    // characters without a table entry, at the range borders
    send_req(REQ_CHAR, 8'h00);
    send_req(REQ_CHAR, 8'hFF);
    send_req(REQ_CHAR, 8'h40);
    send_req(REQ_CHAR, 8'h5B);
    send_req(REQ_CHAR, 8'h60);
    send_req(REQ_CHAR, 8'h7B);
    send_req(REQ_SPARE, 8'hFF);
    run_ticks(40);
    send_req(REQ_PAUSE, 8'hFF);
    send_req(REQ_CHAR, CH_UP_A + 8'd14);
    run_ticks(60);

    set_timing(8'd0, 8'd0, 8'd0, 8'd0);
    random_phase(180);
    set_timing(8'd255, 8'd255, 8'd255, 8'd255);
    random_phase(100);

    // receiver holds off while requests keep coming
    set_timing(8'd1, 8'd3, 8'd1, 8'd3);
    hold_off_go = 1'b1;
    random_phase(220);

    for (int p = 0; p < 3; p++) begin
      set_timing(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
      random_phase(180);
    end
    set_timing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(100);

    gaps_on = 1'b0;
    set_timing(8'd2, 8'd5, 8'd2, 8'd7);
    random_phase(180);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/mck_pkg.sv
design/mck_if.sv
design/mck_lookup.sv
design/mck_keyer.sv
design/morse_code_keyer.sv
tb/mck_keyer_checker.sv
tb/tb_morse_code_keyer.sv
